// ----- src/nnps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler package
// Shared types and fixed constants of the scaler core and its submodules.
// ----------------------------------------------------------------------------
package nnps_pkg;

  localparam int PIXEL_W   = 32;
  localparam int CFG_DIM_W = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ALPHA   = 3'd4;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET  = 9'd16;
  localparam logic [PIXEL_W-1:0]   ALPHA_MASK = 32'hFF00_0000;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [PIXEL_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] source_width;
    logic [CFG_DIM_W-1:0] source_height;
    logic [CFG_DIM_W-1:0] target_width;
    logic [CFG_DIM_W-1:0] target_height;
    logic                 force_alpha;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_RESP = 4'b1000
  } back_state_e;

endpackage

// ----- src/nearest_neighbor_pixel_scaler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour pixel scaler core
// Loads a BGRA source frame into a frame store and emits the destination
// frame in raster order, picking the nearest source pixel for each one.
//
// Requests enter on the in channel: mode 0 writes source_pixel at the next
// frame store address, mode 1 asks for the next destination pixel. Loads give
// no result and are retired at one per cycle while the back end is idle. Each
// emit gives one result on the out channel, after the bit-serial coordinate
// dividers, the frame store read and the result register; the back end takes
// no further request until that result has been registered.
// A two-entry request queue lets the sender keep going while the back end
// works, and the result register holds its value for as long as the receiver
// stalls, after which the back end and then the queue stop taking requests.
// Configuration writes take effect at once and are taken in every cycle; a
// write to any size register restarts the destination scan at the top left.
// Reset restores the default sizes, clears the scan and load position and
// the overflow flag; the frame store content is undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_core #(
  parameter int MAX_DIM     = 256,
  parameter int FRAME_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] source_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dest_pixel_o,
  output logic        row_end_o,
  output logic        frame_end_o,
  output logic        load_overflow_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import nnps_pkg::*;

  cfg_t  cfg_q;
  logic  restart;
  logic  item_valid, item_pop;
  item_t item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT,
        CFG_TARGET_WIDTH, CFG_TARGET_HEIGHT: begin
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= DIM_RESET;
      cfg_q.source_height <= DIM_RESET;
      cfg_q.target_width  <= DIM_RESET;
      cfg_q.target_height <= DIM_RESET;
      cfg_q.force_alpha   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_data_i;
        CFG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_data_i;
        CFG_TARGET_WIDTH:  cfg_q.target_width  <= cfg_data_i;
        CFG_TARGET_HEIGHT: cfg_q.target_height <= cfg_data_i;
        CFG_FORCE_ALPHA:   cfg_q.force_alpha   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  nnps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .source_pixel_i (source_pixel_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  nnps_back #(.MAX_DIM(MAX_DIM), .FRAME_WORDS(FRAME_WORDS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .restart_i       (restart),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_pop_o      (item_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dest_pixel_o    (dest_pixel_o),
    .row_end_o       (row_end_o),
    .frame_end_o     (frame_end_o),
    .load_overflow_o (load_overflow_o)
  );

endmodule

// ----- src/nnps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nnps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/nnps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler coordinate divider
// Restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnps_div #(
  parameter int DW = 9,
  parameter int QW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW+QW-1:0] dividend_i,
  input  logic [DW-1:0]    divisor_i,
  output logic             done_o,
  output logic [QW-1:0]    quotient_o
);

  localparam int SW = DW + QW;
  localparam int CW = $clog2(QW + 1);

  logic [SW-1:0] rem_q, rem_d;
  logic [SW-1:0] dsh_q, dsh_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = dividend_i;
      dsh_d = SW'(divisor_i) << (QW - 1);
      quo_d = '0;
      cnt_d = CW'(QW);
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      dsh_d  = dsh_q >> 1;
      quo_d  = QW'({quo_q, ge});
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/nnps_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler front end
// Accepts requests, classifies them as load or emit and queues them.
// ----------------------------------------------------------------------------
module nnps_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [31:0]            source_pixel_i,
  output logic                   item_valid_o,
  output nnps_pkg::item_t        item_o,
  input  logic                   item_pop_i
);
  import nnps_pkg::*;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      new_item;

  assign in_ready_o   = (cnt_q != QUEUE_DEPTH);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    new_item.op    = mode_i ? OP_EMIT : OP_LOAD;
    new_item.pixel = source_pixel_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !item_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && item_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_DEPTH)
    else $error("request queue count beyond depth");

  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o)
    else $error("pop from empty request queue");

  a_cnt_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !item_pop_i) |=> $stable(cnt_q))
    else $error("request queue count moved without push or pop");

endmodule

// ----- src/nnps_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbour scaler back end
// Executes queued requests: frame store writes, coordinate stepping,
// source lookup and the registered result stage.
// ----------------------------------------------------------------------------
module nnps_back #(
  parameter int MAX_DIM     = 256,
  parameter int FRAME_WORDS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nnps_pkg::cfg_t  cfg_i,
  input  logic            restart_i,
  input  logic            item_valid_i,
  input  nnps_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     dest_pixel_o,
  output logic            row_end_o,
  output logic            frame_end_o,
  output logic            load_overflow_o
);
  import nnps_pkg::*;

  localparam int EW  = $clog2(MAX_DIM + 1);
  localparam int QW  = $clog2(MAX_DIM);
  localparam int AW  = EW + QW;
  localparam int FAW = $clog2(FRAME_WORDS);
  localparam int LW  = FAW + 1;

  function automatic logic [EW-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) begin
      return EW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      return EW'(MAX_DIM);
    end else begin
      return EW'(v);
    end
  endfunction

  back_state_e state_q, state_d;

  logic [EW-1:0]  sw, sh, tw, th;
  logic [QW-1:0]  col_q, row_q;
  logic [AW-1:0]  col_acc_q, row_acc_q;
  logic [LW-1:0]  load_addr_q;
  logic           ovf_q;
  logic           row_end_q, frame_end_q, ovf_snap_q;
  logic [AW-1:0]  pix_addr_q;
  logic           in_range_q;
  logic           out_valid_q, out_row_end_q, out_frame_end_q, out_ovf_q;
  logic [31:0]    out_pixel_q;

  logic           take_load, take_emit, load_fits, load_full;
  logic           row_end, frame_end;
  logic           x_done, y_done;
  logic [QW-1:0]  x_quo, y_quo, xs, ys;
  logic [AW-1:0]  pix_addr_d;
  logic [31:0]    rd_data, pixel_out;
  logic           out_free;

  assign sw = eff_dim(cfg_i.source_width);
  assign sh = eff_dim(cfg_i.source_height);
  assign tw = eff_dim(cfg_i.target_width);
  assign th = eff_dim(cfg_i.target_height);

  assign item_pop_o = item_valid_i && (state_q == ST_IDLE);
  assign take_load  = item_pop_o && (item_i.op == OP_LOAD);
  assign take_emit  = item_pop_o && (item_i.op == OP_EMIT);
  assign load_fits  = (load_addr_q < LW'(FRAME_WORDS));
  assign load_full  = take_load && !load_fits;

  assign row_end   = ((EW'(col_q) + EW'(1)) >= tw);
  assign frame_end = row_end && ((EW'(row_q) + EW'(1)) >= th);

  nnps_div #(.DW(EW), .QW(QW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take_emit),
    .dividend_i (col_acc_q),
    .divisor_i  (tw),
    .done_o     (x_done),
    .quotient_o (x_quo)
  );

  nnps_div #(.DW(EW), .QW(QW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take_emit),
    .dividend_i (row_acc_q),
    .divisor_i  (th),
    .done_o     (y_done),
    .quotient_o (y_quo)
  );

  assign xs         = (sw > EW'(1)) ? x_quo : '0;
  assign ys         = (sh > EW'(1)) ? y_quo : '0;
  assign pix_addr_d = AW'(ys * sw) + AW'(xs);

  nnps_ram #(.WIDTH(PIXEL_W), .DEPTH(FRAME_WORDS)) u_frame_store (
    .clk_i     (clk_i),
    .wr_en_i   (take_load && load_fits),
    .wr_addr_i (load_addr_q[FAW-1:0]),
    .wr_data_i (item_i.pixel),
    .rd_en_i   ((state_q == ST_READ) && in_range_q),
    .rd_addr_i (FAW'(pix_addr_q)),
    .rd_data_o (rd_data)
  );

  assign pixel_out = (in_range_q ? rd_data : '0) | (cfg_i.force_alpha ? ALPHA_MASK : '0);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_emit) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (x_done && y_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      col_acc_q   <= '0;
      row_acc_q   <= '0;
      load_addr_q <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        col_q     <= '0;
        row_q     <= '0;
        col_acc_q <= '0;
        row_acc_q <= '0;
      end else if (take_emit) begin
        if (frame_end) begin
          col_q     <= '0;
          row_q     <= '0;
          col_acc_q <= '0;
          row_acc_q <= '0;
        end else if (row_end) begin
          col_q     <= '0;
          col_acc_q <= '0;
          row_q     <= row_q + QW'(1);
          row_acc_q <= row_acc_q + AW'(sh);
        end else begin
          col_q     <= col_q + QW'(1);
          col_acc_q <= col_acc_q + AW'(sw);
        end
      end
      if (take_emit && frame_end) begin
        load_addr_q <= '0;
        ovf_q       <= 1'b0;
      end else if (take_load) begin
        if (load_fits) begin
          load_addr_q <= load_addr_q + LW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_emit) begin
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
      ovf_snap_q  <= ovf_q;
    end
    if ((state_q == ST_DIV) && x_done && y_done) begin
      pix_addr_q <= pix_addr_d;
      in_range_q <= (32'(pix_addr_d) < 32'(FRAME_WORDS));
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_pixel_q     <= pixel_out;
      out_row_end_q   <= row_end_q;
      out_frame_end_q <= frame_end_q;
      out_ovf_q       <= ovf_snap_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dest_pixel_o    = out_pixel_q;
  assign row_end_o       = out_row_end_q;
  assign frame_end_o     = out_frame_end_q;
  assign load_overflow_o = out_ovf_q;

  a_frame_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_frame_end_q) |-> out_row_end_q)
    else $error("frame end flagged without row end");

  a_load_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_addr_q <= LW'(FRAME_WORDS))
    else $error("load address beyond frame store");

  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(col_q) < tw)
    else $error("destination column beyond target width");

  a_ovf_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(load_full))
    else $error("overflow flag set without a dropped load");

endmodule
